// ===== design/tskvf_pkg.sv =====
package tskvf_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned ValueFrac  = 16;
    localparam int unsigned CovFrac    = 24;
    localparam int unsigned CovWidth   = 32;
    localparam int unsigned DtWidth    = 24;
    localparam int unsigned DtFrac     = 24;
    localparam int unsigned RegCount   = 5;
    localparam int unsigned AddrWidth  = 5;
    localparam int unsigned ProdWidth  = 66;
    localparam int unsigned AccWidth   = 68;
    localparam int unsigned DivWidth   = 58;

    localparam logic [AddrWidth-1:0] ADDR_Q_VELOCITY     = 5'd0;
    localparam logic [AddrWidth-1:0] ADDR_Q_ACCEL        = 5'd4;
    localparam logic [AddrWidth-1:0] ADDR_R_NOISE        = 5'd8;
    localparam logic [AddrWidth-1:0] ADDR_START_VELOCITY = 5'd12;
    localparam logic [AddrWidth-1:0] ADDR_START_ACCEL    = 5'd16;

    localparam logic [31:0] RESET_Q_VELOCITY = 32'd16777;
    localparam logic [31:0] RESET_Q_ACCEL    = 32'd16777;
    localparam logic [31:0] RESET_R_NOISE    = 32'd5033165;
    localparam logic signed [CovWidth-1:0] COV_ONE = CovWidth'(64'sd1 <<< CovFrac);

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_REINIT,
        OP_MUL,
        OP_DIV,
        OP_PUBLISH
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_A_DT,
        ST_AV_DT,
        ST_AA_DT,
        ST_FP01_DT,
        ST_VP,
        ST_P_ALL,
        ST_K0Y,
        ST_K1Y,
        ST_K0P00,
        ST_K0P01,
        ST_K1P00,
        ST_K1P01
    } mul_sel_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t sel;
        logic     div_start;
        logic     div_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic reinit;
    } dp_status_t;

    function automatic logic signed [CovWidth-1:0] sat_cov(input logic signed [AccWidth-1:0] x);
        logic signed [AccWidth-1:0] hi;
        logic signed [AccWidth-1:0] lo;
        hi = AccWidth'((65'sd1 <<< (CovWidth - 1)) - 65'sd1);
        lo = -hi - AccWidth'(1);
        if (x > hi) return hi[CovWidth-1:0];
        if (x < lo) return lo[CovWidth-1:0];
        return x[CovWidth-1:0];
    endfunction

    function automatic logic signed [ValueWidth-1:0] sat_val(input logic signed [AccWidth-1:0] x);
        logic signed [AccWidth-1:0] hi;
        logic signed [AccWidth-1:0] lo;
        hi = AccWidth'((65'sd1 <<< (ValueWidth - 1)) - 65'sd1);
        lo = -hi - AccWidth'(1);
        if (x > hi) return hi[ValueWidth-1:0];
        if (x < lo) return lo[ValueWidth-1:0];
        return x[ValueWidth-1:0];
    endfunction

endpackage

// ===== design/tskvf_datapath.sv =====
module tskvf_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tskvf_pkg::dp_cmd_t                     cmd,
    output tskvf_pkg::dp_status_t                  status,
    input  logic signed [31:0]                     measured_velocity,
    input  logic [23:0]                            time_step,
    input  logic                                   reinit,
    input  logic [31:0]                            q_velocity,
    input  logic [31:0]                            q_accel,
    input  logic [31:0]                            r_noise,
    input  logic signed [31:0]                     start_velocity,
    input  logic signed [31:0]                     start_accel,
    output logic signed [31:0]                     velocity_out,
    output logic signed [31:0]                     accel_out
);
    import tskvf_pkg::*;

    logic signed [ValueWidth-1:0] vel_reg, acc_reg;
    logic signed [CovWidth-1:0]   cvv_reg, cva_reg, cav_reg, caa_reg;
    logic signed [ValueWidth-1:0] meas_reg, vp_reg;
    logic [DtWidth-1:0]           dt_reg;
    logic                         reinit_reg;
    logic signed [AccWidth-1:0]   adt_reg, avdt_reg, aadt_reg, fp01dt_reg;
    logic signed [CovWidth-1:0]   p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [CovWidth-1:0]   k0_reg, k1_reg;
    logic signed [AccWidth-1:0]   k0y_reg, k1y_reg;
    logic signed [AccWidth-1:0]   k0p00_reg, k0p01_reg, k1p00_reg;

    // unsaturated fp00 and fp01; fp01 always fits in 33 bits
    logic signed [AccWidth-1:0] fp01_w;
    logic signed [AccWidth-1:0] fp00_w;
    assign fp01_w = AccWidth'(cva_reg) + aadt_reg;
    assign fp00_w = AccWidth'(cvv_reg) + avdt_reg;

    // shared signed multiplier, floor shift, magnitude clamp at 2^62
    logic signed [32:0]         mul_a;
    logic signed [32:0]         mul_b;
    logic [5:0]                 mul_sh;
    logic signed [ProdWidth-1:0] prod;
    logic signed [ProdWidth-1:0] shifted;
    logic signed [AccWidth-1:0] mul_res;
    logic signed [AccWidth-1:0] y_w;
    logic signed [ProdWidth-1:0] lim;

    always_comb
    begin
        y_w = AccWidth'(meas_reg) - AccWidth'(vp_reg);
        mul_a = '0;
        mul_b = '0;
        mul_sh = 6'(CovFrac);
        case (cmd.sel)
            ST_A_DT:    begin mul_a = 33'(acc_reg); mul_b = 33'({1'b0, dt_reg}); mul_sh = 6'(DtFrac); end
            ST_AV_DT:   begin mul_a = 33'(cav_reg); mul_b = 33'({1'b0, dt_reg}); mul_sh = 6'(DtFrac); end
            ST_AA_DT:   begin mul_a = 33'(caa_reg); mul_b = 33'({1'b0, dt_reg}); mul_sh = 6'(DtFrac); end
            ST_FP01_DT: begin mul_a = fp01_w[32:0];
                              mul_b = 33'({1'b0, dt_reg}); mul_sh = 6'(DtFrac); end
            ST_K0Y:     begin mul_a = 33'(k0_reg); mul_b = y_w[32:0]; end
            ST_K1Y:     begin mul_a = 33'(k1_reg); mul_b = y_w[32:0]; end
            ST_K0P00:   begin mul_a = 33'(k0_reg); mul_b = 33'(p00_reg); end
            ST_K0P01:   begin mul_a = 33'(k0_reg); mul_b = 33'(p01_reg); end
            ST_K1P00:   begin mul_a = 33'(k1_reg); mul_b = 33'(p00_reg); end
            ST_K1P01:   begin mul_a = 33'(k1_reg); mul_b = 33'(p01_reg); end
            default:    begin mul_a = '0; mul_b = '0; end
        endcase
        prod = ProdWidth'(mul_a) * ProdWidth'(mul_b);
        shifted = prod >>> mul_sh;
        lim = ProdWidth'(66'sd1 <<< 62);
        if (shifted > lim) mul_res = AccWidth'(lim);
        else if (shifted < -lim) mul_res = -AccWidth'(lim);
        else mul_res = AccWidth'(shifted);
    end

    // restoring divider, one quotient bit a cycle
    logic [DivWidth-1:0]  div_num_reg;
    logic [DivWidth-1:0]  div_q_reg;
    logic [33:0]          div_den_reg;
    logic [34:0]          div_rem_reg;
    logic [5:0]           div_cnt_reg;
    logic                 div_busy_reg;
    logic                 div_neg_reg;
    logic                 div_zero_reg;
    logic                 div_done_reg;
    logic                 div_sel_reg;
    logic signed [AccWidth-1:0] s_w;
    logic signed [CovWidth-1:0] div_p;
    logic [34:0]          rem_sh;
    logic [DivWidth-1:0]  q_mag;
    logic signed [AccWidth-1:0] q_signed;

    assign s_w = AccWidth'(p00_reg) + AccWidth'({1'b0, r_noise});
    assign div_p = cmd.div_sel ? p10_reg : p00_reg;
    assign rem_sh = {div_rem_reg[33:0], div_num_reg[DivWidth-1]};
    assign q_mag = div_q_reg;
    assign q_signed = div_neg_reg ? -AccWidth'({1'b0, q_mag}) : AccWidth'({1'b0, q_mag});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= 6'(DivWidth);
                div_sel_reg  <= cmd.div_sel;
                div_zero_reg <= (s_w <= 0);
                div_neg_reg  <= div_p[CovWidth-1];
                div_num_reg  <= DivWidth'({1'b0, div_p[CovWidth-1] ? -div_p : div_p}) << CovFrac;
                div_den_reg  <= s_w[33:0];
                div_rem_reg  <= '0;
                div_q_reg    <= '0;
            end
            else if (div_busy_reg)
            begin
                div_num_reg <= div_num_reg << 1;
                if (rem_sh >= {1'b0, div_den_reg})
                begin
                    div_rem_reg <= rem_sh - {1'b0, div_den_reg};
                    div_q_reg   <= {div_q_reg[DivWidth-2:0], 1'b1};
                end
                else
                begin
                    div_rem_reg <= rem_sh;
                    div_q_reg   <= {div_q_reg[DivWidth-2:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg - 6'd1;
                if (div_cnt_reg == 6'd1)
                begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done_reg)
        begin
            if (div_sel_reg) k1_reg <= div_zero_reg ? '0 : sat_cov(q_signed);
            else             k0_reg <= div_zero_reg ? '0 : sat_cov(q_signed);
        end
    end

    assign status.div_done = div_done_reg;
    assign status.reinit   = reinit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg <= '0;
            acc_reg <= '0;
            cvv_reg <= COV_ONE;
            cva_reg <= '0;
            cav_reg <= '0;
            caa_reg <= COV_ONE;
            velocity_out <= '0;
            accel_out <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_REINIT:
                begin
                    vel_reg <= sat_val(AccWidth'(start_velocity));
                    acc_reg <= sat_val(AccWidth'(start_accel));
                    cvv_reg <= COV_ONE;
                    cva_reg <= '0;
                    cav_reg <= '0;
                    caa_reg <= COV_ONE;
                end
                OP_MUL:
                begin
                    case (cmd.sel)
                        ST_K1Y:
                            vel_reg <= sat_val(AccWidth'(vp_reg) + k0y_reg);
                        ST_K1P01:
                        begin
                            acc_reg <= sat_val(AccWidth'(acc_reg) + k1y_reg);
                            cvv_reg <= sat_cov(AccWidth'(p00_reg) - k0p00_reg);
                            cva_reg <= sat_cov(AccWidth'(p01_reg) - k0p01_reg);
                            cav_reg <= sat_cov(AccWidth'(p10_reg) - k1p00_reg);
                            caa_reg <= sat_cov(AccWidth'(p11_reg) - mul_res);
                        end
                        default: ;
                    endcase
                end
                OP_PUBLISH:
                begin
                    velocity_out <= vel_reg;
                    accel_out <= acc_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                meas_reg <= measured_velocity;
                dt_reg <= time_step;
                reinit_reg <= reinit;
            end
            OP_MUL:
            begin
                case (cmd.sel)
                    ST_A_DT:    adt_reg <= mul_res;
                    ST_AV_DT:   avdt_reg <= mul_res;
                    ST_AA_DT:   aadt_reg <= mul_res;
                    ST_FP01_DT: fp01dt_reg <= mul_res;
                    ST_VP:      vp_reg <= sat_val(AccWidth'(vel_reg) + adt_reg);
                    ST_P_ALL:
                    begin
                        p00_reg <= sat_cov(fp00_w + fp01dt_reg + AccWidth'({1'b0, q_velocity}));
                        p01_reg <= sat_cov(fp01_w);
                        p10_reg <= sat_cov(AccWidth'(cav_reg) + aadt_reg);
                        p11_reg <= sat_cov(AccWidth'(caa_reg) + AccWidth'({1'b0, q_accel}));
                    end
                    ST_K0Y:   k0y_reg <= mul_res;
                    ST_K1Y:   k1y_reg <= mul_res;
                    ST_K0P00: k0p00_reg <= mul_res;
                    ST_K0P01: k0p01_reg <= mul_res;
                    ST_K1P00: k1p00_reg <= mul_res;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> div_busy_reg) else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done_reg |-> !div_busy_reg) else $error("divider done while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> !cmd.div_start) else $error("divider restarted while busy");

endmodule

// ===== design/tskvf_control.sv =====
module tskvf_control (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tskvf_pkg::dp_cmd_t    cmd,
    input  tskvf_pkg::dp_status_t status
);
    import tskvf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_PRED,
        S_DIV0,
        S_DIV1,
        S_CORR,
        S_PUB,
        S_OUT
    } state_t;

    state_t   state_reg;
    mul_sel_t step_reg;
    logic     wait_reg;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd.op = OP_IDLE;
        cmd.sel = step_reg;
        cmd.div_start = 1'b0;
        cmd.div_sel = (state_reg == S_DIV1);
        case (state_reg)
            S_IDLE:   if (in_valid) cmd.op = OP_LOAD;
            S_DECIDE: if (status.reinit) cmd.op = OP_REINIT;
            S_PRED:   cmd.op = OP_MUL;
            S_DIV0:   cmd.div_start = !wait_reg;
            S_DIV1:   cmd.div_start = !wait_reg;
            S_CORR:   cmd.op = OP_MUL;
            S_PUB:    cmd.op = OP_PUBLISH;
            default:  cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= ST_A_DT;
            wait_reg  <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (in_valid) state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    step_reg <= ST_A_DT;
                    state_reg <= status.reinit ? S_PUB : S_PRED;
                end
                S_PRED:
                begin
                    if (step_reg == ST_P_ALL)
                    begin
                        state_reg <= S_DIV0;
                        wait_reg <= 1'b0;
                    end
                    else step_reg <= mul_sel_t'(step_reg + 5'd1);
                end
                S_DIV0:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= S_DIV1;
                        wait_reg <= 1'b0;
                    end
                    else wait_reg <= 1'b1;
                end
                S_DIV1:
                begin
                    wait_reg <= 1'b1;
                    if (status.div_done)
                    begin
                        state_reg <= S_CORR;
                        step_reg <= ST_K0Y;
                    end
                end
                S_CORR:
                begin
                    if (step_reg == ST_K1P01) state_reg <= S_PUB;
                    else step_reg <= mul_sel_t'(step_reg + 5'd1);
                end
                S_PUB:
                begin
                    state_reg <= S_OUT;
                    out_valid <= 1'b1;
                end
                S_OUT:
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("word accepted while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD) |=> (state_reg == S_DECIDE)) else $error("load lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUB) |=> out_valid) else $error("publish without result");

endmodule

// ===== design/two_state_kalman_velocity_filter_core.sv =====
// two-state (velocity, acceleration) kalman filter
// input channel: in_valid / in_stall with measured_velocity, time_step, reinit
// output channel: out_valid / out_stall with velocity_estimate, accel_estimate
// one result word for each input word, in order
// config over apb: q_velocity 0x00, q_accel 0x04, r_noise 0x08,
// start_velocity 0x0c, start_accel 0x10; write only while idle
// one word at a time: in_stall stays high from acceptance until the result
// is taken
// a normal word takes 134 cycles: one decode cycle, six shared multiplier
// steps, two 60-cycle serial gain divisions, six correction steps and a publish
// a reinit word takes 2 cycles to its result
// while out_stall is high the result holds and no new word is taken
// reset loads the register defaults, zero state and identity covariance
module two_state_kalman_velocity_filter_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   measured_velocity,
    input  logic [23:0]          time_step,
    input  logic                 reinit,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   velocity_estimate,
    output logic signed [31:0]   accel_estimate
);
    import tskvf_pkg::*;

    logic [31:0] q_velocity_reg, q_accel_reg, r_noise_reg, start_velocity_reg, start_accel_reg;
    dp_cmd_t     cmd;
    dp_status_t  status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_velocity_reg <= RESET_Q_VELOCITY;
            q_accel_reg <= RESET_Q_ACCEL;
            r_noise_reg <= RESET_R_NOISE;
            start_velocity_reg <= '0;
            start_accel_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                ADDR_Q_VELOCITY:     q_velocity_reg <= pwdata;
                ADDR_Q_ACCEL:        q_accel_reg <= pwdata;
                ADDR_R_NOISE:        r_noise_reg <= pwdata;
                ADDR_START_VELOCITY: start_velocity_reg <= pwdata;
                ADDR_START_ACCEL:    start_accel_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_Q_VELOCITY:     prdata = q_velocity_reg;
            ADDR_Q_ACCEL:        prdata = q_accel_reg;
            ADDR_R_NOISE:        prdata = r_noise_reg;
            ADDR_START_VELOCITY: prdata = start_velocity_reg;
            ADDR_START_ACCEL:    prdata = start_accel_reg;
            default:             prdata = '0;
        endcase
    end

    tskvf_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    tskvf_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .measured_velocity (measured_velocity),
        .time_step         (time_step),
        .reinit            (reinit),
        .q_velocity        (q_velocity_reg),
        .q_accel           (q_accel_reg),
        .r_noise           (r_noise_reg),
        .start_velocity    (signed'(start_velocity_reg)),
        .start_accel       (signed'(start_accel_reg)),
        .velocity_out      (velocity_estimate),
        .accel_out         (accel_estimate)
    );

endmodule

// ===== test/two_state_kalman_velocity_filter_core_tb.sv =====
module two_state_kalman_velocity_filter_core_tb;
    import tskvf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 3000000;
    localparam int unsigned HoldCycles = 600;
    localparam longint unsigned MagClamp = 64'd1 << 62;

    typedef struct {
        logic signed [31:0] meas;
        logic [23:0]        dt;
        logic               rein;
    } sample_t;

    typedef struct {
        logic signed [31:0] vel;
        logic signed [31:0] acc;
    } estimate_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] measured_velocity;
    logic [23:0]        time_step;
    logic               reinit;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] velocity_estimate;
    logic signed [31:0] accel_estimate;

    sample_t   sample_q[$];
    estimate_t estimate_q[$];

    // filter state mirror
    logic signed [63:0] vel_s;
    logic signed [63:0] acc_s;
    logic signed [63:0] pvv;
    logic signed [63:0] pva;
    logic signed [63:0] pav;
    logic signed [63:0] paa;
    logic [31:0]        q_vel_r;
    logic [31:0]        q_acc_r;
    logic [31:0]        r_noise_r;
    logic [31:0]        start_vel_r;
    logic [31:0]        start_acc_r;

    int  errors;
    int  gap_left;
    int  stall_left;
    int  hold_count;
    bit  quiet;
    bit  hold_req;
    bit  hold_done;
    longint unsigned cycles;

    two_state_kalman_velocity_filter_core u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .measured_velocity (measured_velocity),
        .time_step         (time_step),
        .reinit            (reinit),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .velocity_estimate (velocity_estimate),
        .accel_estimate    (accel_estimate)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // floor(a*b / 2^sh), magnitude limited to 2^62
    function automatic logic signed [63:0] fixed_mul(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int sh);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] p;
        wa = a;
        wb = b;
        p = (wa * wb) >>> sh;
        if (p > $signed({64'd0, MagClamp}))
            return $signed(MagClamp);
        if (p < -$signed({64'd0, MagClamp}))
            return -$signed(MagClamp);
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] gain_of(input logic signed [63:0] p,
                                                   input logic signed [63:0] s);
        if (s <= 0)
            return 0;
        return clamp32((p * (64'sd1 <<< CovFrac)) / s);
    endfunction

    task automatic filter_update(input sample_t x, output estimate_t e);
        logic signed [63:0] dt;
        logic signed [63:0] vp;
        logic signed [63:0] fp00;
        logic signed [63:0] fp01;
        logic signed [63:0] p00;
        logic signed [63:0] p01;
        logic signed [63:0] p10;
        logic signed [63:0] p11;
        logic signed [63:0] s;
        logic signed [63:0] k0;
        logic signed [63:0] k1;
        logic signed [63:0] y;
        if (x.rein)
        begin
            vel_s = {{32{start_vel_r[31]}}, start_vel_r};
            acc_s = {{32{start_acc_r[31]}}, start_acc_r};
            pvv = 64'sd1 <<< CovFrac;
            pva = 0;
            pav = 0;
            paa = 64'sd1 <<< CovFrac;
        end
        else
        begin
            dt = {40'd0, x.dt};
            vp = clamp32(vel_s + fixed_mul(acc_s, dt, DtFrac));
            fp00 = pvv + fixed_mul(pav, dt, DtFrac);
            fp01 = pva + fixed_mul(paa, dt, DtFrac);
            p00 = clamp32(fp00 + fixed_mul(fp01, dt, DtFrac) + {32'd0, q_vel_r});
            p01 = clamp32(fp01);
            p10 = clamp32(pav + fixed_mul(paa, dt, DtFrac));
            p11 = clamp32(paa + {32'd0, q_acc_r});
            s = p00 + {32'd0, r_noise_r};
            k0 = gain_of(p00, s);
            k1 = gain_of(p10, s);
            y = {{32{x.meas[31]}}, x.meas} - vp;
            vel_s = clamp32(vp + fixed_mul(k0, y, CovFrac));
            acc_s = clamp32(acc_s + fixed_mul(k1, y, CovFrac));
            pvv = clamp32(p00 - fixed_mul(k0, p00, CovFrac));
            pva = clamp32(p01 - fixed_mul(k0, p01, CovFrac));
            pav = clamp32(p10 - fixed_mul(k1, p00, CovFrac));
            paa = clamp32(p11 - fixed_mul(k1, p01, CovFrac));
        end
        e.vel = vel_s[31:0];
        e.acc = acc_s[31:0];
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        sample_t   nxt;
        estimate_t e;
        bit        free;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            measured_velocity <= '0;
            time_step <= '0;
            reinit <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            free = !in_valid;
            if (in_valid && !in_stall)
            begin
                nxt.meas = measured_velocity;
                nxt.dt = time_step;
                nxt.rein = reinit;
                filter_update(nxt, e);
                estimate_q.push_back(e);
                free = 1'b1;
            end
            if (free)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    nxt = sample_q.pop_front();
                    measured_velocity <= nxt.meas;
                    time_step <= nxt.dt;
                    reinit <= nxt.rein;
                    in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 4);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_count <= hold_count + 1;
            if (hold_count == HoldCycles)
                hold_done <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        estimate_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (estimate_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    e = estimate_q.pop_front();
                    if (velocity_estimate !== e.vel)
                    begin
                        $error("velocity_estimate expected %0d actual %0d", e.vel,
                               velocity_estimate);
                        errors++;
                    end
                    if (accel_estimate !== e.acc)
                    begin
                        $error("accel_estimate expected %0d actual %0d", e.acc,
                               accel_estimate);
                        errors++;
                    end
                end
            end
            if (hold_req && !hold_done)
                out_stall <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("two_state_kalman_velocity_filter_core regression: fail");
            $finish;
        end
    end

    task automatic reg_write(input logic [4:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            ADDR_Q_VELOCITY:     q_vel_r = data;
            ADDR_Q_ACCEL:        q_acc_r = data;
            ADDR_R_NOISE:        r_noise_r = data;
            ADDR_START_VELOCITY: start_vel_r = data;
            ADDR_START_ACCEL:    start_acc_r = data;
            default:             ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] qv, input logic [31:0] qa,
                             input logic [31:0] r, input logic [31:0] sv,
                             input logic [31:0] sa);
        reg_write(ADDR_Q_VELOCITY, qv);
        reg_write(ADDR_Q_ACCEL, qa);
        reg_write(ADDR_R_NOISE, r);
        reg_write(ADDR_START_VELOCITY, sv);
        reg_write(ADDR_START_ACCEL, sa);
    endtask

    task automatic add_sample(input logic [31:0] m, input logic [23:0] d, input logic ri);
        sample_t x;
        x.meas = m;
        x.dt = d;
        x.rein = ri;
        sample_q.push_back(x);
    endtask

    task automatic wait_drained();
        while (sample_q.size() > 0 || estimate_q.size() > 0 || in_valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic add_random(input int n);
        logic [23:0] d;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 7))
                0:       d = '0;
                1:       d = 24'hFFFFFF;
                2:       d = $urandom_range(0, 255);
                default: d = $urandom_range(0, 24'hFFFFFF);
            endcase
            if ($urandom_range(0, 3) == 0)
                add_sample($urandom_range(0, 32'h7FFFF) - 32'h40000, d,
                           $urandom_range(0, 24) == 0);
            else
                add_sample($urandom, d, $urandom_range(0, 24) == 0);
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        q_vel_r = RESET_Q_VELOCITY;
        q_acc_r = RESET_Q_ACCEL;
        r_noise_r = RESET_R_NOISE;
        start_vel_r = '0;
        start_acc_r = '0;
        vel_s = 0;
        acc_s = 0;
        pvv = 64'sd1 <<< CovFrac;
        pva = 0;
        pav = 0;
        paa = 64'sd1 <<< CovFrac;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words on reset settings
        add_sample(32'h7FFFFFFF, 24'h000000, 1'b0);
        add_sample(32'h80000000, 24'hFFFFFF, 1'b0);
        add_sample(32'h00000000, 24'h000001, 1'b0);
        add_sample(32'h00010000, 24'h800000, 1'b0);
        add_sample(32'hFFFF0000, 24'h400000, 1'b0);
        add_sample(32'h7FFFFFFF, 24'hFFFFFF, 1'b0);
        add_sample(32'h7FFFFFFF, 24'hFFFFFF, 1'b0);
        add_sample(32'h80000000, 24'hFFFFFF, 1'b0);
        add_sample(32'hFFFFFFFF, 24'hFFFFFF, 1'b1);
        add_sample(32'h12345678, 24'h0A0A0A, 1'b0);
        add_sample(32'h00000000, 24'h000000, 1'b1);
        wait_drained();

        // extreme registers, then reinit to extreme start values
        write_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h7FFFFFFF, 32'h80000000);
        add_sample(32'h00000000, 24'h000000, 1'b1);
        add_sample(32'h80000000, 24'hFFFFFF, 1'b0);
        add_sample(32'h7FFFFFFF, 24'hFFFFFF, 1'b0);
        add_sample(32'h00000000, 24'h000001, 1'b0);
        wait_drained();
        // zero noise: gain of exactly one, and zero innovation sum after collapse
        write_all(32'h00000000, 32'h00000000, 32'h00000000, 32'h80000000, 32'h7FFFFFFF);
        add_sample(32'h00000000, 24'h000000, 1'b1);
        add_sample(32'h00050000, 24'h100000, 1'b0);
        add_sample(32'h00050000, 24'h000000, 1'b0);
        add_sample(32'hFFFB0000, 24'hFFFFFF, 1'b0);
        add_sample(32'h00000000, 24'h000000, 1'b0);
        wait_drained();

        // random settings, with a long hold-off at the receiver
        write_all($urandom_range(0, 32'h00100000), $urandom_range(0, 32'h00100000),
                  $urandom, $urandom, $urandom);
        hold_req = 1'b1;
        add_sample(32'h00000000, 24'h000000, 1'b1);
        add_random(450);
        wait_drained();

        write_all($urandom, $urandom, $urandom_range(0, 32'h01000000),
                  $urandom_range(0, 32'h000FFFFF), $urandom_range(0, 32'h000FFFFF));
        add_sample(32'h00000000, 24'h000000, 1'b1);
        add_random(400);
        wait_drained();

        write_all(32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000);
        add_random(400);
        wait_drained();

        // last stretch with no idling
        quiet = 1'b1;
        write_all(RESET_Q_VELOCITY, RESET_Q_ACCEL, RESET_R_NOISE, $urandom, $urandom);
        add_sample(32'h00000000, 24'h000000, 1'b1);
        add_random(400);
        wait_drained();
        repeat (200) @(posedge clk);

        if (errors == 0)
            $display("two_state_kalman_velocity_filter_core regression: pass");
        else
            $display("two_state_kalman_velocity_filter_core regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tskvf_pkg.sv
design/tskvf_datapath.sv
design/tskvf_control.sv
design/two_state_kalman_velocity_filter_core.sv
test/two_state_kalman_velocity_filter_core_tb.sv
